@@ design/u2a_pkg.sv @@
// Package for the UTF-8 to ASCII transliterator: queue entry type, character
// constants and the code point to ASCII string lookup.
// No dependencies.
package u2a_pkg;

   localparam int U2A_QDEPTH = 4;

   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_DQUOT = 7'h22;
   localparam logic [6:0] CH_SQUOT = 7'h27;
   localparam logic [6:0] CH_LPAR  = 7'h28;
   localparam logic [6:0] CH_RPAR  = 7'h29;
   localparam logic [6:0] CH_STAR  = 7'h2A;
   localparam logic [6:0] CH_DASH  = 7'h2D;
   localparam logic [6:0] CH_DOT   = 7'h2E;
   localparam logic [6:0] CH_LT    = 7'h3C;
   localparam logic [6:0] CH_GT    = 7'h3E;
   localparam logic [6:0] CH_UA    = 7'h41;
   localparam logic [6:0] CH_UC    = 7'h43;
   localparam logic [6:0] CH_UD    = 7'h44;
   localparam logic [6:0] CH_UE    = 7'h45;
   localparam logic [6:0] CH_UI    = 7'h49;
   localparam logic [6:0] CH_UM    = 7'h4D;
   localparam logic [6:0] CH_UN    = 7'h4E;
   localparam logic [6:0] CH_UO    = 7'h4F;
   localparam logic [6:0] CH_UR    = 7'h52;
   localparam logic [6:0] CH_UT    = 7'h54;
   localparam logic [6:0] CH_UU    = 7'h55;
   localparam logic [6:0] CH_UY    = 7'h59;
   localparam logic [6:0] CH_NONE  = 7'h5F;
   localparam logic [6:0] CH_LA    = 7'h61;
   localparam logic [6:0] CH_LC    = 7'h63;
   localparam logic [6:0] CH_LD    = 7'h64;
   localparam logic [6:0] CH_LE    = 7'h65;
   localparam logic [6:0] CH_LH    = 7'h68;
   localparam logic [6:0] CH_LI    = 7'h69;
   localparam logic [6:0] CH_LN    = 7'h6E;
   localparam logic [6:0] CH_LO    = 7'h6F;
   localparam logic [6:0] CH_LS    = 7'h73;
   localparam logic [6:0] CH_LT_T  = 7'h74;
   localparam logic [6:0] CH_LU    = 7'h75;
   localparam logic [6:0] CH_LY    = 7'h79;

   // one queued expansion: cnt characters (0 = nothing), chars[0] goes first
   typedef struct packed {
      logic [2:0]      cnt;
      logic [3:0][6:0] chars;
   } u2a_entry_type;

   function automatic u2a_entry_type u2a_put(input logic [2:0] n, input logic [6:0] c0,
                                             input logic [6:0] c1, input logic [6:0] c2,
                                             input logic [6:0] c3);
      u2a_entry_type e;
      e.cnt      = n;
      e.chars[0] = c0;
      e.chars[1] = c1;
      e.chars[2] = c2;
      e.chars[3] = c3;
      return e;
   endfunction

   // base letter for Latin-1 C0..FF, CH_NONE where there is none
   function automatic logic [6:0] u2a_latin_base(input logic [5:0] idx);
      logic [6:0] b;
      unique case (idx) inside
         [6'd0:6'd5]:   b = CH_UA;
         6'd7:          b = CH_UC;
         [6'd8:6'd11]:  b = CH_UE;
         [6'd12:6'd15]: b = CH_UI;
         6'd16:         b = CH_UD;
         6'd17:         b = CH_UN;
         [6'd18:6'd22]: b = CH_UO;
         6'd24:         b = CH_UO;
         [6'd25:6'd28]: b = CH_UU;
         6'd29:         b = CH_UY;
         [6'd32:6'd37]: b = CH_LA;
         6'd39:         b = CH_LC;
         [6'd40:6'd43]: b = CH_LE;
         [6'd44:6'd47]: b = CH_LI;
         6'd48:         b = CH_LD;
         6'd49:         b = CH_LN;
         [6'd50:6'd54]: b = CH_LO;
         6'd56:         b = CH_LO;
         [6'd57:6'd60]: b = CH_LU;
         6'd61:         b = CH_LY;
         6'd63:         b = CH_LY;
         default:       b = CH_NONE;
      endcase
      return b;
   endfunction

   function automatic u2a_entry_type u2a_translit(input logic [20:0] cp);
      u2a_entry_type e;
      logic [6:0]    b;
      e = '0;
      b = u2a_latin_base(cp[5:0]);
      if (cp < 21'h80) begin
         e = u2a_put(3'd1, cp[6:0], 7'h0, 7'h0, 7'h0);
      end else begin
         unique case (cp)
            21'h2018, 21'h2019, 21'h201A, 21'h2032:
               e = u2a_put(3'd1, CH_SQUOT, 7'h0, 7'h0, 7'h0);
            21'h201C, 21'h201D, 21'h201E, 21'h2033:
               e = u2a_put(3'd1, CH_DQUOT, 7'h0, 7'h0, 7'h0);
            21'h2013, 21'h2014, 21'h2015, 21'h2212:
               e = u2a_put(3'd1, CH_DASH, 7'h0, 7'h0, 7'h0);
            21'h2026:
               e = u2a_put(3'd3, CH_DOT, CH_DOT, CH_DOT, 7'h0);
            21'h2022, 21'h00B7, 21'h25CF:
               e = u2a_put(3'd1, CH_STAR, 7'h0, 7'h0, 7'h0);
            21'h00A0, 21'h2009, 21'h202F:
               e = u2a_put(3'd1, CH_SPACE, 7'h0, 7'h0, 7'h0);
            21'h20AC:
               e = u2a_put(3'd3, CH_UE, CH_UU, CH_UR, 7'h0);
            21'h00A9:
               e = u2a_put(3'd3, CH_LPAR, CH_LC, CH_RPAR, 7'h0);
            21'h2122:
               e = u2a_put(3'd4, CH_LPAR, CH_UT, CH_UM, CH_RPAR);
            21'h2192:
               e = u2a_put(3'd2, CH_DASH, CH_GT, 7'h0, 7'h0);
            21'h2190:
               e = u2a_put(3'd2, CH_LT, CH_DASH, 7'h0, 7'h0);
            default: begin
               if (cp[20:8] == 13'd0 && cp[7:6] == 2'b11) begin
                  if (b != CH_NONE) begin
                     e = u2a_put(3'd1, b, 7'h0, 7'h0, 7'h0);
                  end else begin
                     unique case (cp[7:0])
                        8'hC6:   e = u2a_put(3'd2, CH_UA, CH_UE, 7'h0, 7'h0);
                        8'hE6:   e = u2a_put(3'd2, CH_LA, CH_LE, 7'h0, 7'h0);
                        8'hDF:   e = u2a_put(3'd2, CH_LS, CH_LS, 7'h0, 7'h0);
                        8'hDE:   e = u2a_put(3'd2, CH_UT, CH_LH, 7'h0, 7'h0);
                        8'hFE:   e = u2a_put(3'd2, CH_LT_T, CH_LH, 7'h0, 7'h0);
                        default: e = '0;
                     endcase
                  end
               end
            end
         endcase
      end
      return e;
   endfunction

endpackage

@@ design/utf8_to_ascii_transliterator_top.sv @@
// UTF-8 to ASCII transliterator, top level: front decoder, expansion queue,
// character sender. Depends on u2a_pkg, u2a_front, u2a_queue, u2a_back.
// The expansion of a finished code point is written into the queue, then loaded
// into the back end's output register. Throughput: one byte per cycle; each
// character is a transaction; input stalls once the queue of QUEUE_DEPTH fills.
// Synchronous active-high reset clears the open sequence, the queue and output.
module utf8_to_ascii_transliterator_top #(
   parameter int QUEUE_DEPTH = u2a_pkg::U2A_QDEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] out_char, [7] zero
   output logic       rsp_tlast    // last character of this code point's expansion
);
   import u2a_pkg::*;

   logic          push_valid, push_ready;
   u2a_entry_type push_entry;
   logic          pop_valid, pop_ready;
   u2a_entry_type pop_entry;
   logic [6:0]    out_char;

   u2a_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_eot     (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   u2a_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   u2a_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_char   (out_char),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, out_char};

endmodule

@@ design/u2a_front.sv @@
// Front end: takes raw bytes, runs the UTF-8 sequence decoder and pushes the
// ASCII expansion of each finished code point into the queue.
// Depends on u2a_pkg.
module u2a_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             in_byte,
   input  logic                   in_eot,
   output logic                   push_valid,
   input  logic                   push_ready,
   output u2a_pkg::u2a_entry_type push_entry
);
   import u2a_pkg::*;

   logic [20:0]   code_accum_ff, code_accum_in;
   logic [1:0]    bytes_left_ff, bytes_left_in;
   logic          accept;
   logic          is_cont;
   logic          emit;
   logic [20:0]   cp;
   u2a_entry_type tr;

   assign in_ready = push_ready;
   assign accept   = in_valid && in_ready;
   assign is_cont  = (bytes_left_ff != 2'd0) && (in_byte[7:6] == 2'b10);

   always_comb begin
      code_accum_in = code_accum_ff;
      bytes_left_in = bytes_left_ff;
      emit          = 1'b0;
      cp            = {14'd0, in_byte[6:0]};
      if (is_cont) begin
         cp            = {code_accum_ff[14:0], in_byte[5:0]};
         code_accum_in = cp;
         bytes_left_in = bytes_left_ff - 2'd1;
         if (bytes_left_ff == 2'd1) begin
            emit          = 1'b1;
            code_accum_in = '0;
         end
      end else begin
         // fresh start; a broken sequence is dropped here
         code_accum_in = '0;
         bytes_left_in = 2'd0;
         priority if (!in_byte[7]) begin
            emit = 1'b1;
         end else if (in_byte[7:5] == 3'b110) begin
            code_accum_in = {16'd0, in_byte[4:0]};
            bytes_left_in = 2'd1;
         end else if (in_byte[7:4] == 4'b1110) begin
            code_accum_in = {17'd0, in_byte[3:0]};
            bytes_left_in = 2'd2;
         end else if (in_byte[7:3] == 5'b11110) begin
            code_accum_in = {18'd0, in_byte[2:0]};
            bytes_left_in = 2'd3;
         end else begin
            // stray continuation or invalid lead: dropped
            code_accum_in = '0;
         end
      end
      if (in_eot) begin
         code_accum_in = '0;
         bytes_left_in = 2'd0;
      end
   end

   assign tr         = u2a_translit(cp);
   assign push_entry = tr;
   assign push_valid = accept && emit && (tr.cnt != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         code_accum_ff <= '0;
         bytes_left_ff <= '0;
      end else if (accept) begin
         code_accum_ff <= code_accum_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

@@ design/u2a_queue.sv @@
// Short register queue of pending expansions between front and back ends.
// Depends on u2a_pkg.
module u2a_queue #(
   parameter int DEPTH = u2a_pkg::U2A_QDEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  u2a_pkg::u2a_entry_type push_entry,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output u2a_pkg::u2a_entry_type pop_entry
);
   import u2a_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

   u2a_entry_type         slot_ff [DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ design/u2a_back.sv @@
// Back end: holds one expansion in an output register and sends its
// characters one per transaction, flagging the final one.
// Depends on u2a_pkg.
module u2a_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  u2a_pkg::u2a_entry_type pop_entry,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [6:0]             out_char,
   output logic                   out_last
);
   import u2a_pkg::*;

   u2a_entry_type ent_ff;
   logic          valid_ff, valid_in;
   logic [1:0]    idx_ff, idx_in;
   logic          fire;
   logic          load;

   assign out_valid = valid_ff;
   assign out_char  = ent_ff.chars[idx_ff];
   assign out_last  = ({1'b0, idx_ff} + 3'd1) == ent_ff.cnt;
   assign fire      = valid_ff && out_ready;
   assign pop_ready = !valid_ff || (fire && out_last);
   assign load      = pop_valid && pop_ready;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (fire) begin
         if (out_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff <= pop_entry;
      end
   end

endmodule
